### rtl/hrdr_pkg.sv
// Shared types, constants and the arctangent table of the heading-rate dead reckoning block.
`timescale 1ns / 1ps
package hrdr_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_GYRO_BIAS    = 2'd0;
  localparam logic [1:0] REG_START_X      = 2'd1;
  localparam logic [1:0] REG_START_Y      = 2'd2;
  localparam logic [1:0] REG_START_HEAD   = 2'd3;

  // Serial multiplier geometry.
  localparam int MUL_AW = 37;
  localparam int MUL_BW = 32;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int MUL_CW = 6;

  // Rotator geometry: vector lanes, angle lane and rounded result.
  localparam int XY_W = 36;
  localparam int Z_W  = 34;
  localparam int VW_W = XY_W - 8;

  // 1/K in Q30 and the scaled position limits.
  localparam logic [MUL_BW-1:0] KINV_Q30 = 32'd652032874;
  localparam logic signed [49:0] POS_MAX = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] POS_MIN = -50'sh0_8000_0000_0000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_ROT,
    S_MOVE,
    S_DONE
  } state_e;

  // Rounded atan(2^-i) in binary-angle units, 2^32 per turn.
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] r;
    begin
      unique case (idx)
        5'd0:  r = 32'd536870912;
        5'd1:  r = 32'd316933406;
        5'd2:  r = 32'd167458907;
        5'd3:  r = 32'd85004756;
        5'd4:  r = 32'd42667331;
        5'd5:  r = 32'd21354465;
        5'd6:  r = 32'd10679838;
        5'd7:  r = 32'd5340245;
        5'd8:  r = 32'd2670163;
        5'd9:  r = 32'd1335087;
        5'd10: r = 32'd667544;
        5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;
        5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;
        5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;
        5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;
        5'd19: r = 32'd1304;
        5'd20: r = 32'd652;
        5'd21: r = 32'd326;
        5'd22: r = 32'd163;
        5'd23: r = 32'd81;
        5'd24: r = 32'd41;
        5'd25: r = 32'd20;
        5'd26: r = 32'd10;
        5'd27: r = 32'd5;
        5'd28: r = 32'd3;
        5'd29: r = 32'd1;
        5'd30: r = 32'd1;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage

### rtl/hrdr_mul_serial.sv
// Bit-serial shift-and-add multiplier: signed multiplicand, unsigned multiplier, one bit a cycle.
`timescale 1ns / 1ps
module hrdr_mul_serial import hrdr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [MUL_AW-1:0] a_i,
  input  logic        [MUL_BW-1:0] b_i,
  input  logic        [MUL_CW-1:0] nbits_i,
  output logic signed [MUL_PW-1:0] prod_o,
  output logic                     done_o
);

  logic signed [MUL_PW-1:0] acc_q, acc_d, ash_q, ash_d;
  logic        [MUL_BW-1:0] bsh_q, bsh_d;
  logic        [MUL_CW-1:0] cnt_q, cnt_d;
  logic                     busy_q, busy_d, done_q, done_d;

  // One multiplier bit is consumed per cycle, least significant first.
  always_comb begin
    acc_d  = acc_q;
    ash_d  = ash_q;
    bsh_d  = bsh_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = '0;
      ash_d  = MUL_PW'(a_i);
      bsh_d  = b_i;
      cnt_d  = nbits_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (bsh_q[0]) begin
        acc_d = acc_q + ash_q;
      end
      ash_d = ash_q <<< 1;
      bsh_d = bsh_q >> 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == MUL_CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    ash_q <= ash_d;
    bsh_q <= bsh_d;
  end

  assign prod_o = acc_q;
  assign done_o = done_q;

endmodule

### rtl/hrdr_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, with rounded outputs.
`timescale 1ns / 1ps
module hrdr_cordic import hrdr_pkg::*; #(
  parameter int STEPS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [XY_W-1:0] x_i,
  input  logic signed [XY_W-1:0] y_i,
  input  logic        [31:0]     h_i,
  output logic signed [VW_W-1:0] e_o,
  output logic signed [VW_W-1:0] n_o,
  output logic                   done_o
);

  logic signed [XY_W-1:0] x_q, x_d, y_q, y_d, dx, dy, xr, yr;
  logic signed [Z_W-1:0]  z_q, z_d, ang;
  logic        [4:0]      i_q, i_d;
  logic                   busy_q, busy_d, done_q, done_d, flip;
  logic        [31:0]     h_adj;

  // Quadrant fold so the residual angle starts within a quarter turn.
  assign flip  = (h_i[31:30] == 2'd1) || (h_i[31:30] == 2'd2);
  assign h_adj = flip ? (h_i + 32'h8000_0000) : h_i;

  assign dx  = y_q >>> i_q;
  assign dy  = x_q >>> i_q;
  assign ang = Z_W'($signed({1'b0, atan_lut(i_q)}));

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    i_d    = i_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = flip ? -x_i : x_i;
      y_d    = flip ? -y_i : y_i;
      z_d    = Z_W'($signed(h_adj));
      i_d    = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!z_q[Z_W-1]) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - ang;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + ang;
      end
      i_d = i_q + 1'b1;
      if (i_q == 5'(STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      i_q    <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  // Round to nearest by adding half an LSB before dropping the guard bits.
  assign xr     = x_q + XY_W'(128);
  assign yr     = y_q + XY_W'(128);
  assign e_o    = xr[XY_W-1:8];
  assign n_o    = yr[XY_W-1:8];
  assign done_o = done_q;

endmodule

### rtl/heading_rate_dead_reckoning.sv
// Top level of the heading-rate dead reckoning block: control, pose state and stream ports.
//
// Usage: each request on the s_axis channel is one navigation sample (timestamp, yaw
// rate, forward and starboard body velocity). Each sample yields exactly one pose
// request on m_axis (east, north, heading). Registers are written on cfg_we_i with
// cfg_idx_i selecting gyro bias, start x, start y or start heading; write them only
// while the block is idle.
// The first sample after reset skips the computation and gives the start pose through
// the done state and the output register. Every later sample goes through serial
// scaling by 1/K, the rotator, serial dt multiplication and the handoff to the output
// register. The work is done by the bit-serial multipliers and the one-step-per-cycle
// rotator; one sample is in work at a time.
// s_axis_tready is high only while no sample is in work, so the block takes no new
// sample before it is through with the last one.
// Reset clears the registers, the pose and the first-sample flag.
// When the receiver stalls, the finished pose waits in the output register and
// the block still takes and works on the next sample; it then holds that result
// until the output register frees.
`timescale 1ns / 1ps
module heading_rate_dead_reckoning import hrdr_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // sample_time[31:0], yaw_rate[63:32], vel_forward[87:64], vel_starboard[111:88]
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_east[47:0], pos_north[95:48], heading_out[127:96]
  output logic [127:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [47:0]  cfg_data_i
);

  state_e state_q, state_d;

  logic [31:0] gyro_bias_q, start_head_q;
  logic [47:0] start_x_q, start_y_q;

  logic        seen_first_q;
  logic [31:0] last_time_q, last_rate_q, heading_q;
  logic [23:0] last_fwd_q, last_stbd_q;
  logic [47:0] east_q, north_q;
  logic [15:0] dt_q, dt_in;
  logic [31:0] gap, dr;

  logic         out_valid_q;
  logic [127:0] out_data_q;

  logic accept, out_load, mul_ab_start, mul_c_start, cor_start;
  logic mul_a_done, mul_b_done, mul_c_done, cor_done;

  logic signed [MUL_AW-1:0] mul_a_op, mul_b_op, mul_c_op;
  logic        [MUL_BW-1:0] mul_ab_mult;
  logic        [MUL_CW-1:0] mul_ab_nbits;
  logic signed [MUL_PW-1:0] prod_a, prod_b, prod_c;
  logic signed [VW_W-1:0]   vel_e, vel_n;
  logic signed [49:0]       sum_e, sum_n;
  logic        [47:0]       new_e, new_n;

  assign accept = s_axis_tvalid && s_axis_tready;

  // Sample gap, clamped to sixteen bits, and the bias-corrected rate.
  assign gap   = s_axis_tdata[31:0] - last_time_q;
  assign dt_in = (|gap[31:16]) ? 16'hFFFF : gap[15:0];
  assign dr    = last_rate_q - gyro_bias_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = seen_first_q ? S_SCALE : S_DONE;
      S_SCALE: if (mul_a_done) state_d = S_ROT;
      S_ROT:   if (cor_done) state_d = S_MOVE;
      S_MOVE:  if (mul_a_done) state_d = S_DONE;
      S_DONE:  if (!out_valid_q || m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    s_axis_tready = 1'b0;
    mul_ab_start  = 1'b0;
    mul_c_start   = 1'b0;
    cor_start     = 1'b0;
    out_load      = 1'b0;
    mul_a_op      = MUL_AW'($signed(vel_e));
    mul_b_op      = MUL_AW'($signed(vel_n));
    mul_ab_mult   = MUL_BW'(dt_q);
    mul_ab_nbits  = MUL_CW'(16);
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        mul_ab_start  = accept && seen_first_q;
        mul_c_start   = accept && seen_first_q;
        mul_a_op      = MUL_AW'($signed(last_fwd_q));
        mul_b_op      = MUL_AW'($signed(last_stbd_q));
        mul_ab_mult   = KINV_Q30;
        mul_ab_nbits  = MUL_CW'(30);
      end
      S_SCALE: cor_start = mul_a_done;
      S_ROT:   mul_ab_start = cor_done;
      S_MOVE:  ;
      S_DONE:  out_load = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  assign mul_c_op = MUL_AW'($signed({1'b0, dr}));

  hrdr_mul_serial u_mul_a (
    .clk_i, .rst_ni, .start_i(mul_ab_start), .a_i(mul_a_op), .b_i(mul_ab_mult),
    .nbits_i(mul_ab_nbits), .prod_o(prod_a), .done_o(mul_a_done)
  );

  hrdr_mul_serial u_mul_b (
    .clk_i, .rst_ni, .start_i(mul_ab_start), .a_i(mul_b_op), .b_i(mul_ab_mult),
    .nbits_i(mul_ab_nbits), .prod_o(prod_b), .done_o(mul_b_done)
  );

  hrdr_mul_serial u_mul_c (
    .clk_i, .rst_ni, .start_i(mul_c_start), .a_i(mul_c_op), .b_i(MUL_BW'(dt_in)),
    .nbits_i(MUL_CW'(16)), .prod_o(prod_c), .done_o(mul_c_done)
  );

  hrdr_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .start_i(cor_start),
    .x_i(prod_a[XY_W+21:22]), .y_i(prod_b[XY_W+21:22]), .h_i(heading_q),
    .e_o(vel_e), .n_o(vel_n), .done_o(cor_done)
  );

  // Displacement is the world velocity times dt, floor-shifted by 16; the new position is saturated.
  assign sum_e = $signed(50'($signed(east_q))) + $signed(prod_a[65:16]);
  assign sum_n = $signed(50'($signed(north_q))) + $signed(prod_b[65:16]);
  assign new_e = (sum_e > POS_MAX) ? POS_MAX[47:0] :
                 (sum_e < POS_MIN) ? POS_MIN[47:0] : sum_e[47:0];
  assign new_n = (sum_n > POS_MAX) ? POS_MAX[47:0] :
                 (sum_n < POS_MIN) ? POS_MIN[47:0] : sum_n[47:0];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_bias_q  <= '0;
      start_x_q    <= '0;
      start_y_q    <= '0;
      start_head_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GYRO_BIAS:  gyro_bias_q  <= cfg_data_i[31:0];
        REG_START_X:    start_x_q    <= cfg_data_i;
        REG_START_Y:    start_y_q    <= cfg_data_i;
        REG_START_HEAD: start_head_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Previous sample and pose.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      seen_first_q <= 1'b0;
      last_time_q  <= '0;
      last_rate_q  <= '0;
      last_fwd_q   <= '0;
      last_stbd_q  <= '0;
      heading_q    <= '0;
      east_q       <= '0;
      north_q      <= '0;
      dt_q         <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        last_time_q <= s_axis_tdata[31:0];
        last_rate_q <= s_axis_tdata[63:32];
        last_fwd_q  <= s_axis_tdata[87:64];
        last_stbd_q <= s_axis_tdata[111:88];
        dt_q        <= dt_in;
        if (!seen_first_q) begin
          seen_first_q <= 1'b1;
          heading_q    <= start_head_q;
          east_q       <= start_x_q;
          north_q      <= start_y_q;
        end
      end
      if (state_q == S_MOVE && mul_a_done) begin
        east_q    <= new_e;
        north_q   <= new_n;
        heading_q <= heading_q + prod_c[31:0];
      end
    end
  end

  // Output register parts the result from the sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {heading_q, north_q, east_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // The two vector lanes run in lockstep.
  assert property (@(posedge clk_i) disable iff (!rst_ni) mul_a_done == mul_b_done)
    else $error("vector multipliers out of step");

  // The heading product is ready before the rotation ends.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cor_done |-> !mul_c_done)
    else $error("heading product finished late");

  // The rotator is only started from the scaling phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cor_start |-> state_q == S_SCALE)
    else $error("rotator started out of sequence");

  // Once a sample was seen, the flag stays set.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !$fell(seen_first_q))
    else $error("first-sample flag cleared");

  // A new sample is not taken in the cycle after one was accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> !s_axis_tready)
    else $error("back-to-back accept");

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the heading-rate dead reckoning block.
`timescale 1ns / 1ps
module testbench import hrdr_pkg::*; ();

  localparam int ROT_STEPS = 24;
  localparam longint LIMIT_CYCLES = 3000000;
  localparam longint SAT_HI = 64'sd140737488355327;
  localparam longint SAT_LO = -64'sd140737488355328;

  typedef struct packed {
    logic [23:0] stbd;
    logic [23:0] fwd;
    logic [31:0] rate;
    logic [31:0] stamp;
  } sample_t;

  typedef struct packed {
    logic [31:0] heading;
    logic [47:0] north;
    logic [47:0] east;
  } pose_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = '0;
  logic [47:0]  cfg_data_i = '0;

  heading_rate_dead_reckoning #(.CORDIC_STEPS(ROT_STEPS)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Arctangent steps in binary-angle units.
  localparam longint ANGLE_STEP [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  sample_t sample_queue[$];
  pose_t   pose_queue[$];
  int      src_idle = 0;
  int      sink_stall = 0;
  int      hold_left = 0;
  int      errors = 0;
  int      poses_checked = 0;
  int      sat_hits = 0;
  longint  cycles = 0;
  logic [31:0] next_stamp = '0;

  // Shadow registers and pose state.
  logic [31:0] bias_reg = '0;
  logic [47:0] sx_reg = '0, sy_reg = '0;
  logic [31:0] sh_reg = '0;
  logic        have_first = 1'b0;
  logic [31:0] prev_stamp = '0, prev_rate = '0, pose_heading = '0;
  logic [23:0] prev_fwd = '0, prev_stbd = '0;
  longint      pose_east = 0, pose_north = 0;

  function automatic longint clamp48(longint v);
    if (v > SAT_HI) begin
      sat_hits++;
      return SAT_HI;
    end
    if (v < SAT_LO) begin
      sat_hits++;
      return SAT_LO;
    end
    return v;
  endfunction

  // Body velocity rotated into the world frame by iterative rotation.
  function automatic void body_to_world(input longint f, input longint s,
                                        input logic [31:0] hdg,
                                        output longint we, output longint wn);
    longint x, y, z, dx, dy;
    logic [31:0] h;
    h = hdg;
    x = (f * 64'sd652032874) >>> 22;
    y = (s * 64'sd652032874) >>> 22;
    if (h[31:30] == 2'b01 || h[31:30] == 2'b10) begin
      x = -x;
      y = -y;
      h = h + 32'h8000_0000;
    end
    z = longint'($signed(h));
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ANGLE_STEP[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ANGLE_STEP[i];
      end
    end
    we = (x + 128) >>> 8;
    wn = (y + 128) >>> 8;
  endfunction

  // Advances the pose by one sample and returns the expected output.
  function automatic pose_t advance_pose(sample_t smp);
    pose_t p;
    logic [31:0] gap, dt, dh;
    longint we, wn;
    if (!have_first) begin
      pose_heading = sh_reg;
      pose_east = longint'($signed(sx_reg));
      pose_north = longint'($signed(sy_reg));
      have_first = 1'b1;
    end else begin
      gap = smp.stamp - prev_stamp;
      dt = (gap > 32'd65535) ? 32'd65535 : gap;
      dh = (prev_rate - bias_reg) * dt;
      body_to_world(longint'($signed(prev_fwd)), longint'($signed(prev_stbd)),
                    pose_heading, we, wn);
      pose_east = clamp48(pose_east + ((we * longint'(dt)) >>> 16));
      pose_north = clamp48(pose_north + ((wn * longint'(dt)) >>> 16));
      pose_heading = pose_heading + dh;
    end
    prev_stamp = smp.stamp;
    prev_rate = smp.rate;
    prev_fwd = smp.fwd;
    prev_stbd = smp.stbd;
    p.east = pose_east[47:0];
    p.north = pose_north[47:0];
    p.heading = pose_heading;
    return p;
  endfunction

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycles, what, got, want);
    errors++;
  endtask

  // Input driver: one request per accepted sample, gaps at random.
  always @(posedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (s_axis_tvalid)
        pose_queue.insert(pose_queue.size(), advance_pose(sample_t'(s_axis_tdata)));
      if (sample_queue.size() > 0 && $urandom_range(99) >= src_idle) begin
        s_axis_tdata <= sample_queue.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output monitor: compares each pose request with the oldest expectation.
  always @(posedge clk_i) begin
    pose_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = pose_t'(m_axis_tdata);
        if (pose_queue.size() == 0) begin
          report_mismatch("unexpected pose", got.east, '0);
        end else begin
          want = pose_queue.pop_front();
          poses_checked++;
          if (got.east !== want.east) report_mismatch("pos_east", got.east, want.east);
          if (got.north !== want.north) report_mismatch("pos_north", got.north, want.north);
          if (got.heading !== want.heading)
            report_mismatch("heading_out", got.heading, want.heading);
        end
      end
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= sink_stall);
    end
  end

  // Long receiver hold-off countdown.
  always @(posedge clk_i) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // Cycle limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_GYRO_BIAS:  bias_reg = val[31:0];
      REG_START_X:    sx_reg = val;
      REG_START_Y:    sy_reg = val;
      REG_START_HEAD: sh_reg = val[31:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_sample(input logic [31:0] st, input logic [31:0] rt,
                             input logic [23:0] f, input logic [23:0] s);
    sample_t smp;
    smp.stamp = st;
    smp.rate = rt;
    smp.fwd = f;
    smp.stbd = s;
    sample_queue.insert(sample_queue.size(), smp);
    next_stamp = st;
  endtask

  function automatic logic [23:0] rand_vel();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 24'h7F_FFFF;
    if (r < 10) return 24'h80_0000;
    return 24'($urandom());
  endfunction

  // Random sample with mostly modest gaps, some repeats and some wild jumps.
  task automatic push_random();
    int r;
    logic [31:0] st;
    r = $urandom_range(99);
    if (r < 6) st = next_stamp;
    else if (r < 12) st = $urandom();
    else st = next_stamp + $urandom_range(1, 3000);
    push_sample(st, $urandom(), rand_vel(), rand_vel());
  endtask

  task automatic drain();
    wait (sample_queue.size() == 0 && !s_axis_tvalid && pose_queue.size() == 0);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [31:0] bias, input int idle, input int stall,
                           input int count);
    write_reg(REG_GYRO_BIAS, {16'h0, bias});
    src_idle = idle;
    sink_stall = stall;
    for (int i = 0; i < count; i++) push_random();
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Start pose close to the position limits so saturation is reached.
    write_reg(REG_START_X, 48'h7FFF_FE00_0000);
    write_reg(REG_START_Y, 48'h8000_0200_0000);
    write_reg(REG_START_HEAD, 32'hBFFF_FFFF);
    write_reg(REG_GYRO_BIAS, 32'h0000_1000);

    // Directed samples: first sample, repeats, wraps, extremes, all quadrants.
    push_sample(32'h0000_0100, 32'h7FFF_FFFF, 24'h7F_FFFF, 24'h80_0000);
    push_sample(32'h0000_0100, 32'h8000_0000, 24'h80_0000, 24'h7F_FFFF);
    push_sample(32'h0000_0101, 32'h0000_0000, 24'h7F_FFFF, 24'h7F_FFFF);
    push_sample(32'h0001_0101, 32'hFFFF_FFFF, 24'h80_0000, 24'h80_0000);
    push_sample(32'h0001_0100, 32'h0000_4000, 24'h00_0000, 24'h00_0000);
    push_sample(32'hFFFF_FFFF, 32'h0100_0000, 24'h7F_FFFF, 24'h00_0000);
    push_sample(32'h0000_0010, 32'h4000_0000, 24'h00_0000, 24'h7F_FFFF);
    push_sample(32'h0000_0011, 32'h4000_0000, 24'h7F_FFFF, 24'h00_0000);
    push_sample(32'h0000_0012, 32'h4000_0000, 24'h80_0000, 24'h00_0000);
    push_sample(32'h0000_0013, 32'h4000_0000, 24'h00_0000, 24'h80_0000);
    push_sample(32'h0000_0014, 32'hC000_0000, 24'h12_3456, 24'hED_CBA9);
    push_sample(32'h0000_FFFF, 32'h0000_0001, 24'h7F_FFFF, 24'h7F_FFFF);
    push_sample(32'h0001_FFFF, 32'h0000_0000, 24'h7F_FFFF, 24'h80_0000);
    push_sample(32'h0002_FFFF, 32'h0000_0000, 24'h80_0000, 24'h7F_FFFF);
    push_sample(32'h0003_0000, 32'h5555_5555, 24'h55_5555, 24'hAA_AAAA);
    push_sample(32'h0003_0001, 32'hAAAA_AAAA, 24'hAA_AAAA, 24'h55_5555);
    drain();

    // Start registers rewritten later must not move the pose.
    write_reg(REG_START_X, 48'h0000_0000_0000);
    write_reg(REG_START_Y, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_START_HEAD, 32'h0000_0000);

    run_phase(32'h0000_0000, 0, 0, 300);
    run_phase(32'h7FFF_FFFF, 47, 0, 250);
    run_phase(32'h8000_0000, 0, 47, 250);
    run_phase(32'hFFFF_FF00, 34, 34, 250);

    // Receiver holds off for a long stretch while samples keep coming.
    hold_left = 3000;
    run_phase($urandom(), 0, 0, 80);
    run_phase($urandom(), 20, 20, 270);

    $display("checked %0d poses over seven bias settings, %0d saturated updates",
             poses_checked, sat_hits);
    $display("stalls, gaps, repeated and wrapped timestamps and a long hold-off covered");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### heading_rate_dead_reckoning.f
rtl/hrdr_pkg.sv
rtl/hrdr_mul_serial.sv
rtl/hrdr_cordic.sv
rtl/heading_rate_dead_reckoning.sv
tb/sv/testbench.sv
